[src/tqg_pkg.sv]
// tqg_pkg: shared widths, register indexes, transaction structs and the corner table
// for the tile quad generator. Depends on nothing; every other file uses it.

package tqg_pkg;

  // field widths
  localparam int CELL_W    = 12;
  localparam int ID_W      = 16;
  localparam int ALPHA_W   = 8;
  localparam int TSIZE_W   = 10;
  localparam int ATLAS_W   = 8;
  localparam int MARGIN_W  = 10;
  localparam int SPACING_W = 8;
  localparam int MAP_W     = 12;
  localparam int POS_W     = 22;
  localparam int TEX_W     = 19;
  localparam int PITCH_W   = TSIZE_W + 1;

  // stream and configuration port widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  // divider: quotient bits resolved per clock
  localparam int DIV_BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES         = ID_W / DIV_BITS_PER_CYCLE;

  // default depth of the cell queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // vertex numbering inside one cell
  localparam logic [2:0] FIRST_VERTEX = 3'd0;
  localparam logic [2:0] LAST_VERTEX  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_COLUMNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_MARGIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_SPACING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd7;

  // corner codes: bit 0 = right edge, bit 1 = bottom edge
  localparam logic [1:0] CORNER_TL = 2'b00;
  localparam logic [1:0] CORNER_TR = 2'b01;
  localparam logic [1:0] CORNER_BL = 2'b10;
  localparam logic [1:0] CORNER_BR = 2'b11;

  typedef struct packed {
    logic [TSIZE_W-1:0]   tile_width;
    logic [TSIZE_W-1:0]   tile_height;
    logic [ATLAS_W-1:0]   atlas_columns;
    logic [ATLAS_W-1:0]   atlas_rows;
    logic [MARGIN_W-1:0]  atlas_margin;
    logic [SPACING_W-1:0] atlas_spacing;
    logic [MAP_W-1:0]     map_width;
    logic [MAP_W-1:0]     map_height;
  } cfg_t;

  // one classified cell waiting for the back end
  typedef struct packed {
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [ID_W-1:0]    tile_idm1;
    logic [ALPHA_W-1:0] alpha;
    logic               atlas_ok;
  } cell_t;

  // cell with its atlas column and row resolved
  typedef struct packed {
    cell_t              entry;
    logic [ATLAS_W-1:0] col;
    logic [ID_W-1:0]    row;
  } div_res_t;

  // triangle order: top-left, top-right, bottom-right, top-left, bottom-right, bottom-left
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0:    c = CORNER_TL;
      3'd1:    c = CORNER_TR;
      3'd2:    c = CORNER_BR;
      3'd3:    c = CORNER_TL;
      3'd4:    c = CORNER_BR;
      3'd5:    c = CORNER_BL;
      default: c = CORNER_TL;
    endcase
    return c;
  endfunction

endpackage

[src/tile_quad_generator.sv]
// tile_quad_generator: top level; holds the configuration registers and joins
// front, cell queue, divider and vertex emitter. Depends on tqg_pkg and the tqg_* modules.
//
// Each accepted map cell that draws something yields six vertex transactions on the
// master side (top-left, top-right, bottom-right, top-left, bottom-right, bottom-left),
// tlast on the sixth. Cells with tile id 0, cells off the map and any cell while a
// tile size is zero are accepted and produce nothing. Sustained throughput of drawn
// cells is set by the six output transactions per cell; dropped cells are taken
// one per clock while the queue has room. A drawn cell passes from input to its
// first vertex through the queue, the column/row divider (four quotient bits per
// clock), the origin multiplier register and the output register. The queue of
// QUEUE_DEPTH cells lets input keep flowing while the output stalls.
// Configuration must be written through cfg_wr_en/cfg_index/cfg_wr_data only while
// idle; the block itself does not enforce this.

module tile_quad_generator #(
  parameter int QUEUE_DEPTH = tqg_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // cell_x[11:0], cell_y[23:12], tile_id[39:24], alpha_in[47:40]
  input  logic [tqg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x[21:0], pos_y[43:22], tex_u[62:44], tex_v[81:63], alpha_out[89:82], zero[95:90]
  output logic [tqg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic                               m_axis_tlast,
  input  logic                               cfg_wr_en,
  input  logic [tqg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tqg_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  tqg_pkg::cfg_t     cfg;
  tqg_pkg::cell_t    front_cell;
  tqg_pkg::cell_t    queue_cell;
  tqg_pkg::div_res_t div_res;
  logic              front_push;
  logic              queue_not_full;
  logic              queue_not_empty;
  logic              div_in_ready;
  logic              div_out_valid;
  logic              emit_in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tqg_pkg::REG_TILE_WIDTH:    cfg.tile_width    <= cfg_wr_data[9:0];
        tqg_pkg::REG_TILE_HEIGHT:   cfg.tile_height   <= cfg_wr_data[9:0];
        tqg_pkg::REG_ATLAS_COLUMNS: cfg.atlas_columns <= cfg_wr_data[7:0];
        tqg_pkg::REG_ATLAS_ROWS:    cfg.atlas_rows    <= cfg_wr_data[7:0];
        tqg_pkg::REG_ATLAS_MARGIN:  cfg.atlas_margin  <= cfg_wr_data[9:0];
        tqg_pkg::REG_ATLAS_SPACING: cfg.atlas_spacing <= cfg_wr_data[7:0];
        tqg_pkg::REG_MAP_WIDTH:     cfg.map_width     <= cfg_wr_data;
        tqg_pkg::REG_MAP_HEIGHT:    cfg.map_height    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // classify incoming cells
  tqg_front u_front (
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_data     (s_axis_tdata),
    .queue_ready (queue_not_full),
    .in_ready    (s_axis_tready),
    .push        (front_push),
    .cell_out    (front_cell)
  );

  // decoupling queue
  tqg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_cell),
    .not_full  (queue_not_full),
    .pop       (div_in_ready),
    .not_empty (queue_not_empty),
    .pop_data  (queue_cell)
  );

  // atlas column and row
  tqg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .divisor   (cfg.atlas_columns),
    .in_valid  (queue_not_empty),
    .in_cell   (queue_cell),
    .in_ready  (div_in_ready),
    .out_valid (div_out_valid),
    .out_res   (div_res),
    .out_ready (emit_in_ready)
  );

  // quad origins and vertex walk
  tqg_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (div_out_valid),
    .in_res    (div_res),
    .in_ready  (emit_in_ready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_ready (m_axis_tready)
  );

endmodule

[src/tqg_front.sv]
// tqg_front: unpacks an input cell transaction, drops cells that draw nothing and
// flags ids that fall outside the atlas. Depends on tqg_pkg.

module tqg_front (
  input  tqg_pkg::cfg_t                      cfg,
  input  logic                               in_valid,
  input  logic [tqg_pkg::IN_TDATA_W-1:0]     in_data,
  input  logic                               queue_ready,
  output logic                               in_ready,
  output logic                               push,
  output tqg_pkg::cell_t                     cell_out
);

  logic [tqg_pkg::CELL_W-1:0]    cx;
  logic [tqg_pkg::CELL_W-1:0]    cy;
  logic [tqg_pkg::ID_W-1:0]      id;
  logic [tqg_pkg::ALPHA_W-1:0]   alpha;
  logic [2*tqg_pkg::ATLAS_W-1:0] atlas_area;
  logic                          keep;

  // unpack fields
  assign cx    = in_data[11:0];
  assign cy    = in_data[23:12];
  assign id    = in_data[39:24];
  assign alpha = in_data[47:40];

  // tiles available in the atlas
  assign atlas_area = {8'd0, cfg.atlas_columns} * {8'd0, cfg.atlas_rows};

  // empty cell, off-map cell or zero tile size draws nothing
  assign keep = (id != '0) && (cx < cfg.map_width) && (cy < cfg.map_height) &&
                (cfg.tile_width != '0) && (cfg.tile_height != '0);

  assign cell_out.cell_x    = cx;
  assign cell_out.cell_y    = cy;
  assign cell_out.tile_idm1 = id - 16'd1;
  assign cell_out.alpha     = alpha;
  assign cell_out.atlas_ok  = (cfg.atlas_columns != '0) && (cfg.atlas_rows != '0) &&
                              (id <= atlas_area);

  // dropped cells are still taken, they just never reach the queue
  assign in_ready = queue_ready;
  assign push     = in_valid && queue_ready && keep;

endmodule

[src/tqg_queue.sv]
// tqg_queue: short first-word-fall-through queue of classified cells between the
// front and the back end. Depends on tqg_pkg.

module tqg_queue #(
  parameter int DEPTH = tqg_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tqg_pkg::cell_t push_data,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output tqg_pkg::cell_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tqg_pkg::cell_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[src/tqg_div.sv]
// tqg_div: splits tile id minus one into atlas column and row by a restoring
// division by atlas_columns, four quotient bits per clock. Depends on tqg_pkg.

module tqg_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tqg_pkg::ATLAS_W-1:0]    divisor,
  input  logic                           in_valid,
  input  tqg_pkg::cell_t                 in_cell,
  output logic                           in_ready,
  output logic                           out_valid,
  output tqg_pkg::div_res_t              out_res,
  input  logic                           out_ready
);

  localparam int CNT_W = $clog2(tqg_pkg::DIV_CYCLES + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic                          done;
  tqg_pkg::cell_t                cell_q;
  logic [tqg_pkg::ATLAS_W-1:0]   rem_q;
  logic [tqg_pkg::ID_W-1:0]      dq_q;
  logic [tqg_pkg::ATLAS_W-1:0]   rem_next;
  logic [tqg_pkg::ID_W-1:0]      dq_next;
  logic                          start;

  assign done      = busy && (cnt == CNT_W'(tqg_pkg::DIV_CYCLES));
  assign in_ready  = !busy || (done && out_ready);
  assign start     = in_valid && in_ready;
  assign out_valid = done;

  assign out_res.entry = cell_q;
  assign out_res.col   = rem_q;
  assign out_res.row   = dq_q;

  // four restoring steps; dividend bits shift out the top, quotient bits in the bottom
  always_comb begin
    logic [tqg_pkg::ATLAS_W:0] t;
    rem_next = rem_q;
    dq_next  = dq_q;
    for (int i = 0; i < tqg_pkg::DIV_BITS_PER_CYCLE; i++) begin
      t       = {rem_next, dq_next[tqg_pkg::ID_W-1]};
      dq_next = {dq_next[tqg_pkg::ID_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        rem_next   = tqg_pkg::ATLAS_W'(t - {1'b0, divisor});
        dq_next[0] = 1'b1;
      end else begin
        rem_next = t[tqg_pkg::ATLAS_W-1:0];
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done && out_ready) begin
      busy <= 1'b0;
    end else if (busy && !done) begin
      cnt <= cnt + 1'b1;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      cell_q <= in_cell;
      rem_q  <= '0;
      dq_q   <= in_cell.tile_idm1;
    end else if (busy && !done) begin
      rem_q <= rem_next;
      dq_q  <= dq_next;
    end
  end

endmodule

[src/tqg_emit.sv]
// tqg_emit: scales cell and atlas coordinates into quad origins, then walks the six
// triangle vertices out through a registered output. Depends on tqg_pkg.

module tqg_emit (
  input  logic                             clk,
  input  logic                             rst,
  input  tqg_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  input  tqg_pkg::div_res_t                in_res,
  output logic                             in_ready,
  output logic                             out_valid,
  output logic [tqg_pkg::OUT_TDATA_W-1:0]  out_data,
  output logic                             out_last,
  input  logic                             out_ready
);

  // origin stage
  logic                            a_valid;
  logic [tqg_pkg::POS_W-1:0]       a_px0;
  logic [tqg_pkg::POS_W-1:0]       a_py0;
  logic [tqg_pkg::TEX_W-1:0]       a_tu0;
  logic [tqg_pkg::TEX_W-1:0]       a_tv0;
  logic [tqg_pkg::TSIZE_W-1:0]     a_texw;
  logic [tqg_pkg::TSIZE_W-1:0]     a_texh;
  logic [tqg_pkg::ALPHA_W-1:0]     a_alpha;

  // vertex walker
  logic [tqg_pkg::POS_W-1:0]       e_px0;
  logic [tqg_pkg::POS_W-1:0]       e_py0;
  logic [tqg_pkg::TEX_W-1:0]       e_tu0;
  logic [tqg_pkg::TEX_W-1:0]       e_tv0;
  logic [tqg_pkg::TSIZE_W-1:0]     e_texw;
  logic [tqg_pkg::TSIZE_W-1:0]     e_texh;
  logic [tqg_pkg::ALPHA_W-1:0]     e_alpha;
  logic [2:0]                      k;

  // output register
  logic [tqg_pkg::POS_W-1:0]       pos_x;
  logic [tqg_pkg::POS_W-1:0]       pos_y;
  logic [tqg_pkg::TEX_W-1:0]       tex_u;
  logic [tqg_pkg::TEX_W-1:0]       tex_v;
  logic [tqg_pkg::ALPHA_W-1:0]     alpha_out;

  logic                            emit_free;
  logic                            a_ready;
  logic                            a_load;
  logic                            e_load;
  logic                            e_adv;

  logic [tqg_pkg::PITCH_W-1:0]     pitch_w;
  logic [tqg_pkg::PITCH_W-1:0]     pitch_h;
  logic [tqg_pkg::POS_W-1:0]       px_prod;
  logic [tqg_pkg::POS_W-1:0]       py_prod;
  logic [tqg_pkg::TEX_W-1:0]       tu_prod;
  logic [26:0]                     tv_prod;

  logic [tqg_pkg::POS_W-1:0]       s_px0;
  logic [tqg_pkg::POS_W-1:0]       s_py0;
  logic [tqg_pkg::TEX_W-1:0]       s_tu0;
  logic [tqg_pkg::TEX_W-1:0]       s_tv0;
  logic [tqg_pkg::TSIZE_W-1:0]     s_texw;
  logic [tqg_pkg::TSIZE_W-1:0]     s_texh;
  logic [tqg_pkg::ALPHA_W-1:0]     s_alpha;
  logic [2:0]                      k_next;
  logic [1:0]                      corner;

  // handshakes between the stages
  assign emit_free = !out_valid || (out_ready && (k == tqg_pkg::LAST_VERTEX));
  assign a_ready   = !a_valid || emit_free;
  assign in_ready  = a_ready;
  assign a_load    = in_valid && a_ready;
  assign e_load    = a_valid && emit_free;
  assign e_adv     = out_valid && out_ready && (k != tqg_pkg::LAST_VERTEX);

  // screen origin and atlas origin products
  assign pitch_w = {1'b0, cfg.tile_width} + {3'd0, cfg.atlas_spacing};
  assign pitch_h = {1'b0, cfg.tile_height} + {3'd0, cfg.atlas_spacing};
  assign px_prod = {10'd0, in_res.entry.cell_x} * {12'd0, cfg.tile_width};
  assign py_prod = {10'd0, in_res.entry.cell_y} * {12'd0, cfg.tile_height};
  assign tu_prod = {11'd0, in_res.col} * {8'd0, pitch_w};
  assign tv_prod = {11'd0, in_res.row} * {16'd0, pitch_h};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      k         <= tqg_pkg::FIRST_VERTEX;
    end else begin
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (e_load) begin
        a_valid <= 1'b0;
      end
      if (e_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready && (k == tqg_pkg::LAST_VERTEX)) begin
        out_valid <= 1'b0;
      end
      if (e_load || e_adv) begin
        k <= k_next;
      end
    end
  end

  // origin stage payload; ids beyond the atlas, or any id with an empty atlas, get a zero rectangle
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_px0   <= px_prod;
      a_py0   <= py_prod;
      a_alpha <= in_res.entry.alpha;
      if (in_res.entry.atlas_ok) begin
        a_tu0  <= tu_prod + {9'd0, cfg.atlas_margin};
        a_tv0  <= tv_prod[tqg_pkg::TEX_W-1:0] + {9'd0, cfg.atlas_margin};
        a_texw <= cfg.tile_width;
        a_texh <= cfg.tile_height;
      end else begin
        a_tu0  <= '0;
        a_tv0  <= '0;
        a_texw <= '0;
        a_texh <= '0;
      end
    end
  end

  // pick the quad being walked and the next vertex: the first of a new quad, else the one after the current one
  always_comb begin
    if (e_load) begin
      s_px0   = a_px0;
      s_py0   = a_py0;
      s_tu0   = a_tu0;
      s_tv0   = a_tv0;
      s_texw  = a_texw;
      s_texh  = a_texh;
      s_alpha = a_alpha;
      k_next  = tqg_pkg::FIRST_VERTEX;
    end else begin
      s_px0   = e_px0;
      s_py0   = e_py0;
      s_tu0   = e_tu0;
      s_tv0   = e_tv0;
      s_texw  = e_texw;
      s_texh  = e_texh;
      s_alpha = e_alpha;
      k_next  = k + 3'd1;
    end
    corner = tqg_pkg::corner_of(k_next);
  end

  // quad origins and vertex output
  always_ff @(posedge clk) begin
    if (e_load) begin
      e_px0   <= a_px0;
      e_py0   <= a_py0;
      e_tu0   <= a_tu0;
      e_tv0   <= a_tv0;
      e_texw  <= a_texw;
      e_texh  <= a_texh;
      e_alpha <= a_alpha;
    end
    if (e_load || e_adv) begin
      pos_x     <= s_px0 + (corner[0] ? {12'd0, cfg.tile_width} : '0);
      pos_y     <= s_py0 + (corner[1] ? {12'd0, cfg.tile_height} : '0);
      tex_u     <= s_tu0 + (corner[0] ? {9'd0, s_texw} : '0);
      tex_v     <= s_tv0 + (corner[1] ? {9'd0, s_texh} : '0);
      alpha_out <= s_alpha;
      out_last  <= (k_next == tqg_pkg::LAST_VERTEX);
    end
  end

  assign out_data = {6'd0, alpha_out, tex_v, tex_u, pos_y, pos_x};

endmodule

[src/tqg_checker.sv]
// tqg_checker: port-level assertions for tile_quad_generator, attached by the bind
// at the end of this file. Depends on tqg_pkg and the top level.

module tqg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic [tqg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic                            m_axis_tlast
);

  // a stalled vertex holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  // the next vertex of a cell follows right away with the same alpha
  a_cell_alpha: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[89:82] == $past(m_axis_tdata[89:82])))
    else $error("vertex of a cell missing or alpha changed inside a cell");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind tile_quad_generator tqg_checker u_tqg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/tile_quad_generator_test.sv]
// tile_quad_generator_test: self-checking bench for the tile quad generator, with a
// scoreboard class that predicts the six vertices of each drawn cell.
// Depends on tqg_pkg and the tile_quad_generator RTL only.

module tile_quad_generator_test;
  import tqg_pkg::*;

  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD    = 300;
  localparam int RAND_PHASES  = 10;
  localparam int CELLS_PER_PHASE = 42;

  // corner code per vertex, vertex 0 in the lowest bits
  localparam logic [11:0] QUAD_ORDER = {CORNER_BL, CORNER_BR, CORNER_TL,
                                        CORNER_BR, CORNER_TR, CORNER_TL};

  typedef struct packed {
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [ALPHA_W-1:0] alpha;
    logic               last;
  } vertex_t;

  // predicts vertices per accepted cell and checks them in order
  class quad_board;
    cfg_t    regs;
    vertex_t expected_vertices[$];
    int      fail_count;

    function new();
      regs = '0;
      fail_count = 0;
    endfunction

    function void note_cell(logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
                            logic [ID_W-1:0] id, logic [ALPHA_W-1:0] alpha);
      int unsigned tw, th, cols, rows, px0, py0, u0, v0, du, dv, tid;
      logic [1:0] c;
      vertex_t v;
      tw = regs.tile_width;
      th = regs.tile_height;
      cols = regs.atlas_columns;
      rows = regs.atlas_rows;
      tid = id;
      // empty cell, off the map or zero tile size: nothing drawn
      if (tid == 0 || cx >= regs.map_width || cy >= regs.map_height || tw == 0 || th == 0)
        return;
      px0 = cx * tw;
      py0 = cy * th;
      u0 = 0;
      v0 = 0;
      du = 0;
      dv = 0;
      // atlas rectangle only for ids inside the atlas
      if (cols != 0 && rows != 0 && tid <= cols * rows) begin
        u0 = regs.atlas_margin + ((tid - 1) % cols) * (tw + regs.atlas_spacing);
        v0 = regs.atlas_margin + ((tid - 1) / cols) * (th + regs.atlas_spacing);
        du = tw;
        dv = th;
      end
      for (int k = 0; k < 6; k++) begin
        c = QUAD_ORDER[2*k +: 2];
        v.pos_x = POS_W'(px0 + (c[0] ? tw : 0));
        v.pos_y = POS_W'(py0 + (c[1] ? th : 0));
        v.tex_u = TEX_W'(u0 + (c[0] ? du : 0));
        v.tex_v = TEX_W'(v0 + (c[1] ? dv : 0));
        v.alpha = alpha;
        v.last  = (k == LAST_VERTEX);
        expected_vertices.push_back(v);
      end
    endfunction

    function void check_vertex(logic [OUT_TDATA_W-1:0] data, logic last);
      vertex_t got, want;
      got.pos_x = data[21:0];
      got.pos_y = data[43:22];
      got.tex_u = data[62:44];
      got.tex_v = data[81:63];
      got.alpha = data[89:82];
      got.last  = last;
      if (expected_vertices.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("vertex with none expected: pos %0d,%0d tex %0d,%0d alpha %0d last %0b",
                   got.pos_x, got.pos_y, got.tex_u, got.tex_v, got.alpha, got.last);
        return;
      end
      want = expected_vertices.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("vertex mismatch at %0t", $time);
          $display("  expected pos %0d,%0d tex %0d,%0d alpha %0d last %0b",
                   want.pos_x, want.pos_y, want.tex_u, want.tex_v, want.alpha, want.last);
          $display("  actual   pos %0d,%0d tex %0d,%0d alpha %0d last %0b",
                   got.pos_x, got.pos_y, got.tex_u, got.tex_v, got.alpha, got.last);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   m_axis_tlast;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  quad_board board;
  int sender_gap_pct;
  int sink_gap_pct;
  int sink_hold;

  tile_quad_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if ($urandom_range(1, 100) <= sink_gap_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // output transaction monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_vertex(m_axis_tdata, m_axis_tlast);
  end

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
  endtask

  // write every register; block is idle here
  task automatic apply_setting(cfg_t s);
    put_reg(REG_TILE_WIDTH,    CFG_DATA_W'(s.tile_width));
    put_reg(REG_TILE_HEIGHT,   CFG_DATA_W'(s.tile_height));
    put_reg(REG_ATLAS_COLUMNS, CFG_DATA_W'(s.atlas_columns));
    put_reg(REG_ATLAS_ROWS,    CFG_DATA_W'(s.atlas_rows));
    put_reg(REG_ATLAS_MARGIN,  CFG_DATA_W'(s.atlas_margin));
    put_reg(REG_ATLAS_SPACING, CFG_DATA_W'(s.atlas_spacing));
    put_reg(REG_MAP_WIDTH,     CFG_DATA_W'(s.map_width));
    put_reg(REG_MAP_HEIGHT,    CFG_DATA_W'(s.map_height));
    cfg_wr_en <= 1'b0;
    board.regs = s;
  endtask

  task automatic send_cell(int unsigned x, int unsigned y, int unsigned id, int unsigned a);
    if ($urandom_range(1, 100) <= sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ALPHA_W'(a), ID_W'(id), CELL_W'(y), CELL_W'(x)};
    do @(posedge clk); while (!s_axis_tready);
    board.note_cell(CELL_W'(x), CELL_W'(y), ID_W'(id), ALPHA_W'(a));
  endtask

  // wait out all vertices, then the pipeline of dropped cells
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_t make_setting(int tw, int th, int cols, int rows, int margin,
                                        int spacing, int mw, int mh);
    cfg_t s;
    s.tile_width    = TSIZE_W'(tw);
    s.tile_height   = TSIZE_W'(th);
    s.atlas_columns = ATLAS_W'(cols);
    s.atlas_rows    = ATLAS_W'(rows);
    s.atlas_margin  = MARGIN_W'(margin);
    s.atlas_spacing = SPACING_W'(spacing);
    s.map_width     = MAP_W'(mw);
    s.map_height    = MAP_W'(mh);
    return s;
  endfunction

  function automatic cfg_t draw_setting();
    return make_setting(pick(1, 1023), pick(1, 1023),
                        ($urandom_range(0, 15) == 0) ? 0 : pick(1, 255),
                        ($urandom_range(0, 15) == 0) ? 0 : pick(1, 255),
                        pick(0, 1023), pick(0, 255), pick(1, 4095), pick(1, 4095));
  endfunction

  // mostly cells that draw, the rest empty, off-map or beyond the atlas
  task automatic send_random_cell();
    int unsigned mw, mh, tiles, x, y, id;
    mw = board.regs.map_width;
    mh = board.regs.map_height;
    tiles = board.regs.atlas_columns * board.regs.atlas_rows;
    x  = (mw != 0) ? pick(0, mw - 1) : $urandom_range(0, 4095);
    y  = (mh != 0) ? pick(0, mh - 1) : $urandom_range(0, 4095);
    id = (tiles != 0) ? pick(1, tiles) : $urandom_range(1, 65535);
    case ($urandom_range(0, 15))
      0: id = 0;
      1: x = $urandom_range(0, 4095);
      2: y = $urandom_range(0, 4095);
      3: id = $urandom_range(0, 65535);
      4: id = (tiles < 65535) ? $urandom_range(tiles + 1, 65535) : id;
      default: ;
    endcase
    send_cell(x, y, id, $urandom_range(0, 255));
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_TILE_WIDTH;
    cfg_wr_data = '0;
    sender_gap_pct = 20;
    sink_gap_pct = 20;
    sink_hold = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // small atlas: first and last tile, beyond atlas, empty and off-map cells
    apply_setting(make_setting(16, 8, 8, 4, 3, 2, 64, 48));
    send_cell(0, 0, 1, 255);
    send_cell(63, 47, 32, 0);
    send_cell(5, 6, 33, 128);
    send_cell(1, 1, 0, 77);
    send_cell(64, 0, 1, 1);
    send_cell(0, 48, 1, 1);
    send_cell(4095, 4095, 65535, 255);
    send_cell(10, 20, 9, 200);
    send_cell(7, 3, 8, 100);
    settle();

    // zero tile width, empty map, zero tile height
    apply_setting(make_setting(0, 5, 4, 4, 0, 0, 10, 10));
    send_cell(1, 1, 1, 50);
    settle();
    apply_setting(make_setting(5, 5, 4, 4, 0, 0, 0, 10));
    send_cell(0, 0, 1, 50);
    settle();
    apply_setting(make_setting(5, 0, 4, 4, 0, 0, 10, 10));
    send_cell(2, 2, 3, 9);
    settle();

    // zero atlas columns, then zero atlas rows: positions with zero texture
    apply_setting(make_setting(5, 7, 0, 4, 9, 1, 10, 10));
    send_cell(2, 2, 1, 9);
    settle();
    apply_setting(make_setting(5, 7, 4, 0, 9, 1, 10, 10));
    send_cell(3, 3, 2, 9);
    settle();

    // every register at its maximum
    apply_setting(make_setting(1023, 1023, 255, 255, 1023, 255, 4095, 4095));
    send_cell(4094, 4094, 65025, 255);
    send_cell(0, 0, 1, 0);
    send_cell(4094, 0, 65026, 17);
    send_cell(0, 4094, 255, 1);
    send_cell(4095, 0, 1, 1);
    settle();

    // random phases; the last ones run without idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0)
        apply_setting(make_setting(1, 1, 1, 1, 0, 0, 1, 1));
      else if (p == 1)
        apply_setting(make_setting(1023, 1023, 255, 255, 1023, 255, 4095, 4095));
      else
        apply_setting(draw_setting());
      if (p >= RAND_PHASES - 2) begin
        sender_gap_pct = 0;
        sink_gap_pct = 0;
      end else begin
        sender_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        sink_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      end
      // receiver holds off while cells keep coming, so the input backs up
      if (p == 3)
        sink_hold = LONG_HOLD;
      for (int n = 0; n < CELLS_PER_PHASE; n++)
        send_random_cell();
      settle();
    end

    if (board.fail_count == 0 && board.expected_vertices.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
